// File: hdl/urm_pkg.sv
// ----------------------------------------------------------------------------
// urm_pkg: shared types and constants of the ultrasonic ranger
// Request and result structs, configuration struct and register indexes,
// the phase encoding and the constants of the tick-to-centimetre conversion.
// ----------------------------------------------------------------------------
package urm_pkg;

    localparam int COUNT_WIDTH     = 16;
    localparam int DIST_WIDTH      = 11;
    localparam int TRIG_LEN_WIDTH  = 8;
    localparam int TIMEOUT_WIDTH   = 16;
    localparam int OFFSET_WIDTH    = 10;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TRIGGER_LENGTH = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT        = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFFSET         = CFG_INDEX_WIDTH'(2);

    localparam logic [TRIG_LEN_WIDTH-1:0] TRIG_LEN_RESET = TRIG_LEN_WIDTH'(10);
    localparam logic [TIMEOUT_WIDTH-1:0]  TIMEOUT_RESET  = TIMEOUT_WIDTH'(10000);
    localparam logic [OFFSET_WIDTH-1:0]   OFFSET_RESET   = OFFSET_WIDTH'(30);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [DIST_WIDTH-1:0]  DIST_MAX  = {DIST_WIDTH{1'b1}};

    // floor(count*17/1000) as (count*CONV_MULT) >> CONV_SHIFT, exact over the count range
    localparam int CONV_SHIFT      = COUNT_WIDTH + 10;
    localparam int CONV_MULT_WIDTH = COUNT_WIDTH + 5;
    localparam longint unsigned CONV_MULT_FULL =
        ((longint'(17) << CONV_SHIFT) + longint'(999)) / longint'(1000);
    localparam logic [CONV_MULT_WIDTH-1:0] CONV_MULT = CONV_MULT_WIDTH'(CONV_MULT_FULL);
    localparam int PROD_WIDTH = COUNT_WIDTH + CONV_MULT_WIDTH;
    localparam int QUOT_WIDTH = PROD_WIDTH - CONV_SHIFT;
    localparam int DIFF_WIDTH = (QUOT_WIDTH > DIST_WIDTH) ? QUOT_WIDTH : DIST_WIDTH;
    localparam int CMP_WIDTH  = (COUNT_WIDTH > TIMEOUT_WIDTH) ? COUNT_WIDTH : TIMEOUT_WIDTH;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2
    } t_phase;

    typedef struct packed {
        logic start_request;
        logic echo_level;
    } t_in_item;

    typedef struct packed {
        logic                  trigger_level;
        logic [DIST_WIDTH-1:0] distance_cm;
        logic                  busy_res;
        logic                  result_ready;
        logic                  timed_out;
    } t_out_item;

    typedef struct packed {
        logic [TRIG_LEN_WIDTH-1:0] trigger_length_us;
        logic [TIMEOUT_WIDTH-1:0]  timeout_us;
        logic [OFFSET_WIDTH-1:0]   offset_cm;
    } t_cfg;

endpackage

// File: hdl/urm_cfg_regs.sv
// ----------------------------------------------------------------------------
// urm_cfg_regs: configuration registers
// Holds trigger length, timeout and offset, written through the index port.
// ----------------------------------------------------------------------------
module urm_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [urm_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [urm_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output urm_pkg::t_cfg                       o_cfg
);
    import urm_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_length_us <= TRIG_LEN_RESET;
            r_cfg.timeout_us        <= TIMEOUT_RESET;
            r_cfg.offset_cm         <= OFFSET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TRIGGER_LENGTH: r_cfg.trigger_length_us <= i_cfg_data[TRIG_LEN_WIDTH-1:0];
                CFG_TIMEOUT:        r_cfg.timeout_us        <= i_cfg_data[TIMEOUT_WIDTH-1:0];
                CFG_OFFSET:         r_cfg.offset_cm         <= i_cfg_data[OFFSET_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hdl/urm_convert.sv
// ----------------------------------------------------------------------------
// urm_convert: tick count to distance
// One reciprocal multiply for floor(count*17/1000), offset subtract, clamping.
// ----------------------------------------------------------------------------
module urm_convert (
    input  logic [urm_pkg::COUNT_WIDTH-1:0]  i_count,
    input  logic [urm_pkg::OFFSET_WIDTH-1:0] i_offset,
    output logic [urm_pkg::DIST_WIDTH-1:0]   o_distance
);
    import urm_pkg::*;

    logic [PROD_WIDTH-1:0] product;
    logic [QUOT_WIDTH-1:0] quotient;
    logic [DIFF_WIDTH-1:0] quot_ext;
    logic [DIFF_WIDTH-1:0] offset_ext;
    logic [DIFF_WIDTH-1:0] diff;

    assign product    = PROD_WIDTH'(i_count) * PROD_WIDTH'(CONV_MULT);
    assign quotient   = product[PROD_WIDTH-1:CONV_SHIFT];
    assign quot_ext   = DIFF_WIDTH'(quotient);
    assign offset_ext = DIFF_WIDTH'(i_offset);
    assign diff       = quot_ext - offset_ext;

    always_comb begin
        priority if (quot_ext <= offset_ext) begin
            o_distance = '0;
        end else if (diff > DIFF_WIDTH'(DIST_MAX)) begin
            o_distance = DIST_MAX;
        end else begin
            o_distance = diff[DIST_WIDTH-1:0];
        end
    end

endmodule

// File: hdl/urm_ctrl.sv
// ----------------------------------------------------------------------------
// urm_ctrl: measurement sequencer
// Phase, elapsed counter, echo edge detect and latched distance; produces
// the result of each accepted tick.
// ----------------------------------------------------------------------------
module urm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  urm_pkg::t_in_item  i_item,
    input  urm_pkg::t_cfg      i_cfg,
    output urm_pkg::t_out_item o_result
);
    import urm_pkg::*;

    t_phase                  r_phase;
    t_phase                  n_phase;
    logic [COUNT_WIDTH-1:0]  r_count;
    logic [COUNT_WIDTH-1:0]  n_count;
    logic                    r_echo_prev;
    logic [DIST_WIDTH-1:0]   r_dist;
    logic [DIST_WIDTH-1:0]   n_dist;

    t_phase                  cur_phase;
    logic [COUNT_WIDTH-1:0]  cur_count;
    logic [COUNT_WIDTH-1:0]  count_inc;
    logic                    fall;
    logic                    trig_done;
    logic                    wait_expired;
    logic [DIST_WIDTH-1:0]   conv_dist;
    logic                    trig;
    logic                    ready;
    logic                    tmo;

    urm_convert u_convert (
        .i_count    (r_count),
        .i_offset   (i_cfg.offset_cm),
        .o_distance (conv_dist)
    );

    // a start request restarts the measurement
    assign cur_phase    = i_item.start_request ? PH_TRIG : r_phase;
    assign cur_count    = i_item.start_request ? '0 : r_count;
    assign count_inc    = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
    assign fall         = r_echo_prev && !i_item.echo_level;
    assign trig_done    = count_inc >= COUNT_WIDTH'(i_cfg.trigger_length_us);
    assign wait_expired = (CMP_WIDTH'(count_inc) >= CMP_WIDTH'(i_cfg.timeout_us))
                          || (count_inc == COUNT_MAX);

    // next state
    always_comb begin
        n_phase = cur_phase;
        n_count = cur_count;
        unique case (cur_phase)
            PH_TRIG: begin
                if (trig_done) begin
                    n_phase = PH_WAIT;
                    n_count = '0;
                end else begin
                    n_count = count_inc;
                end
            end
            PH_WAIT: begin
                if (fall || wait_expired) begin
                    n_phase = PH_IDLE;
                    n_count = '0;
                end else begin
                    n_count = count_inc;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        trig   = 1'b0;
        ready  = 1'b0;
        tmo    = 1'b0;
        n_dist = r_dist;
        unique case (cur_phase)
            PH_TRIG: begin
                trig = 1'b1;
            end
            PH_WAIT: begin
                if (fall) begin
                    n_dist = conv_dist;
                    ready  = 1'b1;
                end else if (wait_expired) begin
                    n_dist = '0;
                    tmo    = 1'b1;
                end
            end
            default: begin
                if (fall) begin
                    n_dist = '0;
                    ready  = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_echo_prev <= 1'b0;
            r_dist      <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_echo_prev <= i_item.echo_level;
            r_dist      <= n_dist;
        end
    end

    assign o_result.trigger_level = trig;
    assign o_result.distance_cm   = n_dist;
    assign o_result.busy_res      = (n_phase == PH_TRIG) || (n_phase == PH_WAIT);
    assign o_result.result_ready  = ready;
    assign o_result.timed_out     = tmo;

endmodule

// File: hdl/ultrasonic_range_measure.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_measure: ultrasonic time-of-flight ranger
// A request's result is captured in the output register on acceptance; one
// request per cycle is taken unless the output stalls, set by the single
// pass from state registers through converter multiply into output register.
// Synchronous active-low reset restores register defaults, idles the
// sequencer, clears counter, echo history and distance, empties the output.
// ----------------------------------------------------------------------------
module ultrasonic_range_measure (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  urm_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output urm_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [urm_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [urm_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);
    import urm_pkg::*;

    t_cfg      cfg;
    t_out_item result;
    logic      in_accept;
    logic      r_out_valid;
    t_out_item r_out_data;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    urm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    urm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_ready_tmo_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.result_ready && o_out_data.timed_out))
        else $error("reading and timeout flagged together");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.trigger_level) |-> o_out_data.busy_res)
        else $error("trigger high without busy");

    a_tmo_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.timed_out)
            |-> (o_out_data.distance_cm == '0 && !o_out_data.busy_res))
        else $error("timeout left distance or busy set");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("request stalled with empty output register");

endmodule
